/* rtl/u8u16_pkg.sv */
`timescale 1ns / 1ps

package u8u16_pkg;

    // byte class as seen by the decoder
    typedef enum logic [1:0] {
        K_ASCII,
        K_CONT,
        K_LEAD,
        K_SKIP
    } t_kind;

    // result status codes
    localparam logic [1:0] ST_CHAR      = 2'd0;
    localparam logic [1:0] ST_BAD_CONT  = 2'd1;
    localparam logic [1:0] ST_TRUNC     = 2'd2;

    // substitute for values that do not fit one code unit
    localparam logic [15:0] REPLACEMENT = 16'h003F;

    // classified byte passed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  bits;   // payload bits, lead marker already masked off
        logic [2:0]  nrem;   // continuation bytes a lead byte opens
        logic        last;
    } t_item;

    // bit position of a 6-bit group: n * 6
    function automatic logic [4:0] six_times(input logic [2:0] n);
        logic [4:0] w;
        begin
            w = {2'b00, n};
            return (w << 2) + (w << 1);
        end
    endfunction

endpackage

/* rtl/utf8_to_utf16_decoder.sv */
`timescale 1ns / 1ps
// channel   | signals                          | payload
// ----------+----------------------------------+----------------------------------
// byte in   | s_tvalid s_tready s_tdata s_tlast| tdata[7:0] byte, tlast last byte
// unit out  | m_tvalid m_tready m_tdata m_tuser| tdata[15:0] code unit, tuser status
//
// one byte per cycle sustained while the queue has room; an accepted byte enters the queue
// and is later decoded from the queue into the output register.
// the decode step is a single register update per byte (accumulator, count, halt flag).
// reset (i_rst_n low, synchronous) empties the queue and clears decoder state.
// input stalls only when the queue is full; output stalls hold the result
// register while the queue keeps absorbing bytes.

module utf8_to_utf16_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_unit
    output logic [1:0]  m_tuser     // [1:0] status
);
    import u8u16_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item push_item;
    t_item q_item;

    // classify incoming bytes
    u8u16_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .i_full   (full),
        .o_push   (push),
        .o_item   (push_item)
    );

    // decouple classifier from decoder
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // decode and present results
    u8u16_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/u8u16_front.sv */
`timescale 1ns / 1ps

module u8u16_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] byte_value
    input  logic                 s_tlast,   // last_byte
    input  logic                 i_full,
    output logic                 o_push,
    output u8u16_pkg::t_item     o_item
);
    import u8u16_pkg::*;

    // accept whenever the queue has room
    assign s_tready = !i_full;
    assign o_push   = s_tvalid && !i_full;

    // classify the byte by its leading ones
    always_comb begin
        o_item.last = s_tlast;
        o_item.kind = K_SKIP;
        o_item.bits = s_tdata;
        o_item.nrem = 3'd0;
        case (s_tdata) inside
            8'b0???????: begin
                o_item.kind = K_ASCII;
            end
            8'b10??????: begin
                o_item.kind = K_CONT;
                o_item.bits = {2'b00, s_tdata[5:0]};
            end
            8'b110?????: begin
                o_item.kind = K_LEAD;
                o_item.bits = {3'b000, s_tdata[4:0]};
                o_item.nrem = 3'd1;
            end
            8'b1110????: begin
                o_item.kind = K_LEAD;
                o_item.bits = {4'b0000, s_tdata[3:0]};
                o_item.nrem = 3'd2;
            end
            8'b11110???: begin
                o_item.kind = K_LEAD;
                o_item.bits = {5'b00000, s_tdata[2:0]};
                o_item.nrem = 3'd3;
            end
            8'b111110??: begin
                o_item.kind = K_LEAD;
                o_item.bits = {6'b000000, s_tdata[1:0]};
                o_item.nrem = 3'd4;
            end
            8'b1111110?: begin
                o_item.kind = K_LEAD;
                o_item.bits = {7'b0000000, s_tdata[0]};
                o_item.nrem = 3'd5;
            end
            default: begin
                o_item.kind = K_SKIP;
            end
        endcase
    end

endmodule

/* rtl/u8u16_queue.sv */
`timescale 1ns / 1ps

module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8u16_pkg::t_item     i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output u8u16_pkg::t_item     o_item
);
    import u8u16_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/u8u16_back.sv */
`timescale 1ns / 1ps

module u8u16_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  u8u16_pkg::t_item     i_item,
    output logic                 o_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] code_unit
    output logic [1:0]           m_tuser    // [1:0] status
);
    import u8u16_pkg::*;

    logic [30:0] r_acc;
    logic [2:0]  r_rem;
    logic        r_halt;
    logic        r_out_valid;
    logic [15:0] r_code;
    logic [1:0]  r_status;

    logic [30:0] n_acc;
    logic [2:0]  n_rem;
    logic        n_halt;
    logic        emit;
    logic [15:0] code;
    logic [1:0]  status;
    logic [2:0]  rem_dec;
    logic [30:0] cont_acc;
    logic        step;

    // take the next queued byte when the output slot is free or draining
    assign step  = i_valid && (!r_out_valid || m_tready);
    assign o_pop = step;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_code;
    assign m_tuser  = r_status;

    // decode one byte against the open sequence
    always_comb begin
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_halt   = r_halt;
        emit     = 1'b0;
        code     = 16'd0;
        status   = ST_CHAR;
        rem_dec  = r_rem - 3'd1;
        cont_acc = r_acc | ({25'd0, i_item.bits[5:0]} << six_times(rem_dec));
        if (!r_halt) begin
            if (r_rem == 3'd0) begin
                case (i_item.kind)
                    K_ASCII: begin
                        emit = 1'b1;
                        code = {8'd0, i_item.bits};
                    end
                    K_LEAD: begin
                        n_acc = {23'd0, i_item.bits} << six_times(i_item.nrem);
                        n_rem = i_item.nrem;
                        if (i_item.last) begin
                            emit   = 1'b1;
                            status = ST_TRUNC;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_item.kind != K_CONT) begin
                // broken sequence halts until the buffer ends
                emit   = 1'b1;
                status = ST_BAD_CONT;
                n_acc  = '0;
                n_rem  = 3'd0;
                n_halt = 1'b1;
            end else begin
                n_rem = rem_dec;
                if (rem_dec == 3'd0) begin
                    emit  = 1'b1;
                    code  = (|cont_acc[30:16]) ? REPLACEMENT : cont_acc[15:0];
                    n_acc = '0;
                end else begin
                    n_acc = cont_acc;
                    if (i_item.last) begin
                        emit   = 1'b1;
                        status = ST_TRUNC;
                    end
                end
            end
        end
        // end of buffer returns to idle
        if (i_item.last) begin
            n_acc  = '0;
            n_rem  = 3'd0;
            n_halt = 1'b0;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_rem  <= 3'd0;
            r_halt <= 1'b0;
        end else if (step) begin
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_halt <= n_halt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= emit;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_code   <= code;
            r_status <= status;
        end
    end

endmodule

/* rtl/u8u16_checker.sv */
`timescale 1ns / 1ps

module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import u8u16_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == ST_CHAR || m_tuser == ST_BAD_CONT || m_tuser == ST_TRUNC))
        else $error("undefined status code");

    // status results carry a zero code unit
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != ST_CHAR |-> m_tdata == 16'd0)
        else $error("status result with nonzero code unit");

    // reset clears the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // accepted input transaction carries known data
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |-> !$isunknown({s_tdata, s_tlast}))
        else $error("unknown input data accepted");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* dv/utf8_to_utf16_decoder_tb.sv */
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_tb;
    import u8u16_pkg::*;

    // one decoded code unit or status as seen on the output channel
    typedef struct packed {
        logic [15:0] unit;
        logic [1:0]  status;
    } t_unit_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] byte_value
    logic        s_tlast = 1'b0;      // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [15:0] code_unit
    logic [1:0]  m_tuser;             // [1:0] status

    // decoder state mirrored on the testbench side
    logic [30:0] acc_cp = '0;
    logic [2:0]  cont_left = '0;
    logic        halt_flag = 1'b0;

    t_unit_rec   pending_units[$];
    int          err_count = 0;
    int          sent_bytes = 0;      // bytes handed to the block
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    utf8_to_utf16_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // decode one byte; returns 1 when the byte yields a code unit or a status
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_unit_rec rec);
        int          lead;
        logic [7:0]  mask;
        bit          has_unit;
        begin
            has_unit = 1'b0;
            rec = '0;
            lead = 0;
            if (halt_flag) begin
                // bytes ignored until the buffer ends
            end else if (cont_left == 3'd0) begin
                while (lead < 7 && b[7 - lead]) lead++;
                if (lead == 0) begin
                    rec = '{unit: {8'h00, b}, status: ST_CHAR};
                    has_unit = 1'b1;
                end else if (lead >= 2 && lead <= 6) begin
                    mask = (8'd1 << (7 - lead)) - 8'd1;
                    acc_cp = 31'(b & mask) << ((lead - 1) * 6);
                    cont_left = 3'(lead - 1);
                    if (last) begin
                        rec = '{unit: 16'h0000, status: ST_TRUNC};
                        has_unit = 1'b1;
                    end
                end
                // stray continuation byte or 0xFE / 0xFF gives nothing
            end else if (b[7:6] != 2'b10) begin
                rec = '{unit: 16'h0000, status: ST_BAD_CONT};
                has_unit = 1'b1;
                acc_cp = '0;
                cont_left = '0;
                halt_flag = 1'b1;
            end else begin
                cont_left = cont_left - 3'd1;
                acc_cp = acc_cp | (31'(b[5:0]) << (cont_left * 6));
                if (cont_left == 3'd0) begin
                    rec.unit = (acc_cp[30:16] != '0) ? REPLACEMENT : acc_cp[15:0];
                    rec.status = ST_CHAR;
                    acc_cp = '0;
                    has_unit = 1'b1;
                end else if (last) begin
                    rec = '{unit: 16'h0000, status: ST_TRUNC};
                    has_unit = 1'b1;
                end
            end
            if (last) begin
                acc_cp = '0;
                cont_left = '0;
                halt_flag = 1'b0;
            end
            return has_unit;
        end
    endfunction

    // drive one byte, wait for its transaction, then predict its outcome
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_unit_rec rec;
        begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= b;
            s_tlast <= last;
            do @(posedge i_clk); while (!s_tready);
            if (decode_byte(b, last, rec)) pending_units = {pending_units, rec};
            sent_bytes++;
        end
    endtask

    // hold off the sender until every predicted result has come out
    task automatic wait_drain();
        begin
            s_tvalid <= 1'b0;
            while (pending_units.size() != 0) @(posedge i_clk);
            repeat (8) @(posedge i_clk);
        end
    endtask

    // output check, oldest prediction first
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_units.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual unit %h status %0d",
                         $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                if (m_tdata !== pending_units[0].unit) begin
                    $display("%0t: code unit mismatch: expected %h, actual %h",
                             $time, pending_units[0].unit, m_tdata);
                    err_count++;
                end
                if (m_tuser !== pending_units[0].status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, pending_units[0].status, m_tuser);
                    err_count++;
                end
                void'(pending_units.pop_front());
            end
        end
    end

    function automatic logic [7:0] lead_for(input int len);
        logic [7:0] ones;
        logic [7:0] mask;
        begin
            ones = 8'hFF << (8 - len);
            mask = (8'd1 << (7 - len)) - 8'd1;
            return ones | (8'($urandom) & mask);
        end
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic int pick_len();
        int r;
        begin
            r = $urandom_range(9);
            if (r < 3) return 2;
            if (r < 6) return 3;
            if (r < 8) return 4;
            if (r < 9) return 5;
            return 6;
        end
    endfunction

    // one random buffer: mostly well-formed sequences, some broken ones and noise
    task automatic send_random_buffer();
        logic [7:0] bytes_q[$];
        logic [7:0] b;
        int         nseq;
        int         r;
        int         len;
        int         k;
        begin
            nseq = $urandom_range(1, 6);
            for (int s = 0; s < nseq; s++) begin
                r = $urandom_range(99);
                if (r < 30) begin
                    bytes_q = {bytes_q, 8'($urandom_range(0, 127))};
                end else if (r < 85) begin
                    len = pick_len();
                    bytes_q = {bytes_q, lead_for(len)};
                    for (int i = 1; i < len; i++) bytes_q = {bytes_q, cont_byte()};
                end else if (r < 90) begin
                    if ($urandom_range(3) == 0)
                        bytes_q = {bytes_q, 8'($urandom_range(254, 255))};
                    else
                        bytes_q = {bytes_q, cont_byte()};
                end else if (r < 97) begin
                    // bad continuation partway through a sequence
                    len = pick_len();
                    bytes_q = {bytes_q, lead_for(len)};
                    k = $urandom_range(0, len - 2);
                    for (int i = 0; i < k; i++) bytes_q = {bytes_q, cont_byte()};
                    b = 8'($urandom);
                    if (b[7:6] == 2'b10) b[6] = 1'b1;
                    bytes_q = {bytes_q, b};
                end else begin
                    bytes_q = {bytes_q, 8'($urandom)};
                end
            end
            // buffer cut inside a sequence
            if ($urandom_range(9) == 0) begin
                len = pick_len();
                bytes_q = {bytes_q, lead_for(len)};
                k = $urandom_range(0, len - 2);
                for (int i = 0; i < k; i++) bytes_q = {bytes_q, cont_byte()};
            end
            foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
        end
    endtask

    task automatic test_single_byte();
        begin
            send_byte(8'h00, 1'b0);
            send_byte(8'h7F, 1'b0);
        end
    endtask

    // stray bytes are dropped, including one that ends the buffer
    task automatic test_stray_bytes();
        begin
            send_byte(8'h80, 1'b0);
            send_byte(8'hFE, 1'b0);
            send_byte(8'hFF, 1'b1);
        end
    endtask

    // 2, 3, 4 and 6 byte forms; above 16 bits turns into the substitute
    task automatic test_multibyte_forms();
        begin
            send_byte(8'hC2, 1'b0);
            send_byte(8'hA9, 1'b0);
            send_byte(8'hEF, 1'b0);
            send_byte(8'hBF, 1'b0);
            send_byte(8'hBF, 1'b0);
            send_byte(8'hF0, 1'b0);
            send_byte(8'h9F, 1'b0);
            send_byte(8'h98, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'hFC, 1'b0);
            send_byte(8'h84, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'hBF, 1'b1);
        end
    endtask

    // bad continuation halts until the last byte
    task automatic test_bad_continuation();
        begin
            send_byte(8'hE2, 1'b0);
            send_byte(8'h41, 1'b0);
            send_byte(8'h7F, 1'b1);
        end
    endtask

    // buffer ends right after a lead byte, then after a partial sequence
    task automatic test_truncated_buffer();
        begin
            send_byte(8'hC3, 1'b1);
            send_byte(8'hE2, 1'b0);
            send_byte(8'h82, 1'b1);
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        int start;
        begin
            src_idle_pct = src_pct;
            sink_stall_pct = sink_pct;
            start = sent_bytes;
            while (sent_bytes - start < n_items) send_random_buffer();
            wait_drain();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte();
        test_stray_bytes();
        test_multibyte_forms();
        test_bad_continuation();
        test_truncated_buffer();
        wait_drain();

        test_random_traffic(0, 0, 120);
        test_random_traffic(81, 0, 120);
        test_random_traffic(0, 81, 120);
        test_random_traffic(12, 12, 120);
        test_random_traffic(0, 0, 120);

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_units.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule
